// File: hdl/ahpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahpc_pkg
// Shared sizes, codes and widths of the anti-Hebbian pair count update block.
// ----------------------------------------------------------------------------
package ahpc_pkg;

    localparam int MAX_SPIKES = 16;
    localparam int IDX_W      = (MAX_SPIKES > 1) ? $clog2(MAX_SPIKES) : 1;
    localparam int FILL_W     = $clog2(MAX_SPIKES + 1);
    localparam int PAIR_W     = $clog2(MAX_SPIKES * MAX_SPIKES + 1);
    localparam int CNT_W      = (PAIR_W > 9) ? PAIR_W : 9;

    localparam int TIME_W     = 32;
    localparam int WEIGHT_W   = 17;
    localparam int RATE_W     = 17;
    localparam int WINDOW_W   = 32;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 9;
    localparam int PROD_W     = RATE_W + CNT_W;

    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PRE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POST   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [WEIGHT_W-1:0] ONE_FIX        = 17'd65536;
    localparam logic [RATE_W-1:0]   RATE_RESET     = 17'd655;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 32'd100;
    localparam logic [COUNT_W-1:0]  COUNT_FIELD_MAX = 9'd511;

endpackage

// File: hdl/anti_hebbian_pair_count_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anti_hebbian_pair_count_update
// Collects pre and post spike times, counts pairs closer than the window
// with one shared compare unit, and lowers the weight by rate times count.
// ----------------------------------------------------------------------------
// a pre or post spike word is stored in its list, or dropped when it is full
// a finish word runs the scan, drain, multiply and output states into the
// output register (no scan or drain if either list is empty); the single
// pair comparator sets the scan length, and an untaken result holds the block
// handshake: one word at a time, ready again once the result is registered
// reset: fills, dropped flag and handshake cleared; rate 655, window 100
// ----------------------------------------------------------------------------
module anti_hebbian_pair_count_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // spike_time [31:0], current_weight [48:32], zero fill
    input  logic [ahpc_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // kind [1:0]
    input  logic [ahpc_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // new_weight [16:0], pair_count [25:17], weight_changed [26],
    // spikes_dropped [27], zero fill
    output logic [ahpc_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [ahpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ahpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import ahpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_MUL   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [RATE_W-1:0]   r_rate;
    logic [WINDOW_W-1:0] r_window;
    logic [FILL_W-1:0]   r_pre_fill, r_post_fill;
    logic                r_overflow;
    logic [IDX_W-1:0]    r_i, r_j;
    logic                r_cmp_vld;
    logic [CNT_W-1:0]    r_count;
    logic [WEIGHT_W-1:0] r_cur;
    logic [PROD_W-1:0]   r_prod;
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    logic [KIND_W-1:0]   in_kind;
    logic [TIME_W-1:0]   in_time;
    logic [WEIGHT_W-1:0] in_weight;
    logic                in_acc;
    logic                pre_we, post_we;
    logic [TIME_W-1:0]   pre_rd, post_rd;
    logic [TIME_W:0]     diff;
    logic [TIME_W-1:0]   abs_diff;
    logic                hit;
    logic                i_last, j_last;
    logic [RATE_W-1:0]   rate_eff;
    logic                out_free;
    logic                changed;
    logic [PROD_W-1:0]   cur_ext, rem;
    logic [WEIGHT_W-1:0] new_w;
    logic [COUNT_W-1:0]  count_fld;

    assign in_kind   = s_axis_tuser;
    assign in_time   = s_axis_tdata[TIME_W-1:0];
    assign in_weight = s_axis_tdata[TIME_W +: WEIGHT_W];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign pre_we  = in_acc && (in_kind == KIND_PRE)
                     && (r_pre_fill < FILL_W'(MAX_SPIKES));
    assign post_we = in_acc && (in_kind == KIND_POST)
                     && (r_post_fill < FILL_W'(MAX_SPIKES));

    ahpc_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SPIKES)) u_pre_ram (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (r_pre_fill[IDX_W-1:0]),
        .i_wdata (in_time),
        .i_raddr (r_i),
        .o_rdata (pre_rd)
    );

    ahpc_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SPIKES)) u_post_ram (
        .i_clk   (i_clk),
        .i_we    (post_we),
        .i_waddr (r_post_fill[IDX_W-1:0]),
        .i_wdata (in_time),
        .i_raddr (r_j),
        .o_rdata (post_rd)
    );

    // shared pair comparator
    assign diff     = {1'b0, pre_rd} - {1'b0, post_rd};
    assign abs_diff = diff[TIME_W] ? (~diff[TIME_W-1:0] + TIME_W'(1)) : diff[TIME_W-1:0];
    assign hit      = abs_diff < r_window;

    assign i_last = (FILL_W'(r_i) + FILL_W'(1)) == r_pre_fill;
    assign j_last = (FILL_W'(r_j) + FILL_W'(1)) == r_post_fill;

    assign rate_eff = (r_rate > ONE_FIX) ? ONE_FIX : r_rate;
    assign out_free = !r_m_valid || m_axis_tready;

    // weight update from the registered product
    assign changed = (r_prod != '0);
    assign cur_ext = PROD_W'(r_cur);
    assign rem     = cur_ext - r_prod;
    always_comb begin
        if (!changed) begin
            new_w = r_cur;
        end else if (cur_ext >= r_prod) begin
            new_w = (rem > PROD_W'(ONE_FIX)) ? ONE_FIX : rem[WEIGHT_W-1:0];
        end else begin
            new_w = '0;
        end
    end
    assign count_fld = (r_count > CNT_W'(COUNT_FIELD_MAX)) ? COUNT_FIELD_MAX
                                                            : r_count[COUNT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (in_kind == KIND_FINISH)) begin
                    if ((r_pre_fill != '0) && (r_post_fill != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_SCAN: begin
                if (i_last && j_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rate   <= RATE_RESET;
            r_window <= WINDOW_RESET;
            r_pre_fill  <= '0;
            r_post_fill <= '0;
            r_overflow  <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE:   r_rate   <= i_cfg_wdata[RATE_W-1:0];
                    CFG_WINDOW: r_window <= i_cfg_wdata[WINDOW_W-1:0];
                    default: ;
                endcase
            end

            if (pre_we) begin
                r_pre_fill <= r_pre_fill + FILL_W'(1);
            end
            if (post_we) begin
                r_post_fill <= r_post_fill + FILL_W'(1);
            end
            if (in_acc && (((in_kind == KIND_PRE) && !pre_we)
                           || ((in_kind == KIND_POST) && !post_we))) begin
                r_overflow <= 1'b1;
            end

            if ((r_state == S_OUT) && out_free) begin
                r_m_valid   <= 1'b1;
                r_pre_fill  <= '0;
                r_post_fill <= '0;
                r_overflow  <= 1'b0;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (in_kind == KIND_FINISH)) begin
            r_cur   <= in_weight;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
            if (r_cmp_vld && hit) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(rate_eff) * PROD_W'(r_count);
        end
        if ((r_state == S_OUT) && out_free) begin
            r_m_data <= M_DATA_W'({r_overflow, changed, count_fld, new_w});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre_fill <= FILL_W'(MAX_SPIKES)) && (r_post_fill <= FILL_W'(MAX_SPIKES)))
        else $error("spike list fill beyond capacity");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_pre_fill != '0) && (r_post_fill != '0)))
        else $error("pair scan started on an empty list");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && out_free) |=>
        ((r_pre_fill == '0) && (r_post_fill == '0) && !r_overflow && r_m_valid))
        else $error("lists not cleared after result");

    a_weight_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[WEIGHT_W + COUNT_W]) |->
        (r_m_data[WEIGHT_W-1:0] <= ONE_FIX))
        else $error("changed weight above one");

endmodule

// File: hdl/ahpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ahpc_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/tb_anti_hebbian_pair_count_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_anti_hebbian_pair_count_update
// Feeds pre and post spike times and finish words through the stream port,
// predicts every weight update from its own copy of the spike lists and
// registers, and checks each result word field by field. Directed cases
// cover time and weight extremes, empty lists, rate saturation, zero rate,
// zero window and one long hold-off; random frames, some dropping spikes,
// follow under six register settings, most with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_anti_hebbian_pair_count_update;
    import ahpc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int PHASE_WORDS  = 220;

    typedef struct packed {
        logic [WEIGHT_W-1:0] new_weight;
        logic [COUNT_W-1:0]  pair_count;
        logic                weight_changed;
        logic                spikes_dropped;
    } weight_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // predicted state of the block
    logic [TIME_W-1:0]   pre_list [MAX_SPIKES];
    logic [TIME_W-1:0]   post_list [MAX_SPIKES];
    int                  pre_cnt = 0;
    int                  post_cnt = 0;
    logic                spill_seen = 1'b0;
    logic [RATE_W-1:0]   rate_reg = RATE_RESET;
    logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;

    weight_result_t expected_weights [$];

    bit src_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_hold_len = 0;
    int err_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int dropped_results = 0;
    int changed_results = 0;
    int cycle_count = 0;

    anti_hebbian_pair_count_update u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[anti_hebbian_pair_count_update] ERROR");
            $finish;
        end
    end

    function automatic void update_prediction(input logic [KIND_W-1:0] kind,
                                              input logic [TIME_W-1:0] stamp,
                                              input logic [WEIGHT_W-1:0] wt);
        int unsigned       pairs;
        longint unsigned   dec;
        longint unsigned   wnew;
        logic [RATE_W-1:0] eff_rate;
        logic [TIME_W-1:0] diff;
        weight_result_t    r;
        case (kind)
            KIND_PRE: begin
                if (pre_cnt < MAX_SPIKES) begin
                    pre_list[pre_cnt] = stamp;
                    pre_cnt++;
                end else begin
                    spill_seen = 1'b1;
                end
            end
            KIND_POST: begin
                if (post_cnt < MAX_SPIKES) begin
                    post_list[post_cnt] = stamp;
                    post_cnt++;
                end else begin
                    spill_seen = 1'b1;
                end
            end
            KIND_FINISH: begin
                pairs = 0;
                eff_rate = (rate_reg > ONE_FIX) ? ONE_FIX : rate_reg;
                wnew = wt;
                r.weight_changed = 1'b0;
                if (pre_cnt != 0 && post_cnt != 0) begin
                    for (int i = 0; i < pre_cnt; i++) begin
                        for (int j = 0; j < post_cnt; j++) begin
                            diff = (pre_list[i] > post_list[j]) ? pre_list[i] - post_list[j]
                                                                : post_list[j] - pre_list[i];
                            if (diff < window_reg)
                                pairs++;
                        end
                    end
                    if (eff_rate != 0 && pairs != 0) begin
                        dec = eff_rate;
                        dec = dec * pairs;
                        wnew = (wnew >= dec) ? wnew - dec : 0;
                        if (wnew > ONE_FIX)
                            wnew = ONE_FIX;
                        r.weight_changed = 1'b1;
                    end
                end
                r.new_weight = wnew[WEIGHT_W-1:0];
                r.pair_count = (pairs > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : pairs[COUNT_W-1:0];
                r.spikes_dropped = spill_seen;
                expected_weights.push_back(r);
                pre_cnt = 0;
                post_cnt = 0;
                spill_seen = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] stamp,
                             input logic [WEIGHT_W-1:0] wt);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, wt, stamp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        update_prediction(kind, stamp, wt);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_weights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_params(input logic [CFG_DATA_W-1:0] rate_word,
                              input logic [CFG_DATA_W-1:0] window_word);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_RATE;
        i_cfg_wdata <= rate_word;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_WINDOW;
        i_cfg_wdata <= window_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rate_reg   = rate_word[RATE_W-1:0];
        window_reg = window_word;
    endtask

    // spikes of both kinds, random order, in base..base+spread, then the finish word
    task automatic send_frame(input int n_pre, input int n_post, input logic [TIME_W-1:0] base,
                              input int unsigned spread, input logic [WEIGHT_W-1:0] wt);
        int left_pre;
        int left_post;
        logic [KIND_W-1:0] k;
        left_pre  = n_pre;
        left_post = n_post;
        while (left_pre + left_post > 0) begin
            if ($urandom_range(0, 29) == 0)
                send_word(KIND_IGNORED, $urandom, WEIGHT_W'($urandom_range(0, 131071)));
            if (left_post == 0 || (left_pre != 0 && $urandom_range(0, 1) == 0)) begin
                k = KIND_PRE;
                left_pre--;
            end else begin
                k = KIND_POST;
                left_post--;
            end
            send_word(k, base + $urandom_range(0, spread),
                      WEIGHT_W'($urandom_range(0, 131071)));
        end
        send_word(KIND_FINISH, $urandom, wt);
    endtask

    function automatic int pick_fill();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r < 15)
            return $urandom_range(1, 5);
        if (r < 18)
            return $urandom_range(6, 12);
        return $urandom_range(13, 20);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return ONE_FIX;
        return WEIGHT_W'($urandom_range(0, 65536));
    endfunction

    initial begin : rx_side
        int gap;
        gap = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                gap = rx_hold_len;
                rx_hold_len = 0;
            end
            if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic report_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_val, act_val);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_result
        weight_result_t exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_weights.size() == 0) begin
                $display("%0t unexpected result word: expected none, actual %h",
                         $time, m_axis_tdata);
                err_count++;
            end else begin
                exp_r = expected_weights.pop_front();
                if (m_axis_tdata[16:0] !== exp_r.new_weight)
                    report_field("new_weight", exp_r.new_weight, m_axis_tdata[16:0]);
                if (m_axis_tdata[25:17] !== exp_r.pair_count)
                    report_field("pair_count", exp_r.pair_count, m_axis_tdata[25:17]);
                if (m_axis_tdata[26] !== exp_r.weight_changed)
                    report_field("weight_changed", exp_r.weight_changed, m_axis_tdata[26]);
                if (m_axis_tdata[27] !== exp_r.spikes_dropped)
                    report_field("spikes_dropped", exp_r.spikes_dropped, m_axis_tdata[27]);
                results_checked++;
                if (exp_r.spikes_dropped)
                    dropped_results++;
                if (exp_r.weight_changed)
                    changed_results++;
            end
        end
    end

    task automatic test_reset_defaults();
        send_word(KIND_PRE, 32'd1000, '0);
        send_word(KIND_POST, 32'd1050, '0);
        send_word(KIND_POST, 32'd1100, '0);
        send_word(KIND_FINISH, '0, ONE_FIX);
    endtask

    task automatic test_empty_lists();
        send_word(KIND_FINISH, '0, 17'h1FFFF);
        send_word(KIND_PRE, 32'd5, '0);
        send_word(KIND_FINISH, '0, 17'd12345);
    endtask

    task automatic test_time_extremes();
        send_word(KIND_PRE, 32'h0000_0000, 17'h1FFFF);
        send_word(KIND_POST, 32'hFFFF_FFFF, 17'h1FFFF);
        send_word(KIND_PRE, 32'hFFFF_FFFF, '0);
        send_word(KIND_IGNORED, 32'hFFFF_FFFF, 17'h1FFFF);
        send_word(KIND_FINISH, 32'hFFFF_FFFF, '0);
    endtask

    task automatic test_overweight_clamp();
        set_params(32'd1, 32'hFFFF_FFFF);
        send_word(KIND_PRE, 32'd7, '0);
        send_word(KIND_POST, 32'd9, '0);
        send_word(KIND_FINISH, '0, 17'h1FFFF);
    endtask

    task automatic test_rate_saturation();
        set_params(32'h0001_FFFF, 32'd1);
        send_word(KIND_PRE, 32'd10, '0);
        send_word(KIND_POST, 32'd10, '0);
        send_word(KIND_FINISH, '0, ONE_FIX);
    endtask

    task automatic test_zero_rate_and_window();
        set_params(32'd0, 32'hFFFF_FFFF);
        send_word(KIND_PRE, 32'd3, '0);
        send_word(KIND_POST, 32'd3, '0);
        send_word(KIND_FINISH, '0, 17'd40000);
        set_params(32'd655, 32'd0);
        send_word(KIND_PRE, 32'd3, '0);
        send_word(KIND_POST, 32'd3, '0);
        send_word(KIND_FINISH, '0, 17'd40000);
    endtask

    // receiver holds off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        set_params(32'd655, 32'd1000);
        rx_hold_len = 400;
        repeat (5) send_frame(2, 2, $urandom, 1500, pick_weight());
    endtask

    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] rates [6];
        logic [CFG_DATA_W-1:0] windows [6];
        int phase_words;
        int n_pre;
        int n_post;
        int unsigned spread;
        rates   = '{32'd655, 32'd65536, 32'd0, 32'd1, 32'd0, 32'd40000};
        windows = '{32'd100, 32'hFFFF_FFFF, 32'd5000, 32'd1, 32'd0, 32'h8000_0000};
        rates[4]   = $urandom_range(1, 65535);
        windows[4] = $urandom_range(1, 1 << 20);
        for (int p = 0; p < 6; p++) begin
            set_params(rates[p], windows[p]);
            src_idle_on = (p < 5);
            rx_idle_on  = (p < 5);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                n_pre  = pick_fill();
                n_post = pick_fill();
                if (window_reg == 0 || $urandom_range(0, 9) == 0)
                    spread = $urandom_range(0, 255);
                else if (window_reg < 32'h4000_0000)
                    spread = window_reg * 2;
                else
                    spread = $urandom;
                send_frame(n_pre, n_post, $urandom, spread, pick_weight());
                phase_words += n_pre + n_post + 1;
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_PRE;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_RATE;
        i_cfg_wdata   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_on = 1'b1;
        rx_idle_on  = 1'b1;
        test_reset_defaults();
        test_empty_lists();
        test_time_extremes();
        test_overweight_clamp();
        test_rate_saturation();
        test_zero_rate_and_window();
        test_backpressure();
        test_random_frames();

        wait_idle();
        $display("covered %0d words and %0d weight updates (%0d changed, %0d with drops)",
                 words_sent, results_checked, changed_results, dropped_results);
        $display("register settings swept rate 0..saturated and window 0..full range");
        if (err_count == 0) begin
            $display("[anti_hebbian_pair_count_update] OK");
        end else begin
            $display("[anti_hebbian_pair_count_update] ERROR");
        end
        $finish;
    end

endmodule
